FILE: hw/rtl/lir_pkg.sv
// Shared types and constants for the linear-interpolation resampler.
// No dependencies; every other file of the block imports this package.
package lir_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_OUT_DEF      = 16;

    // Step register: unsigned Q4.16, source samples per output sample.
    localparam int                    STEP_WIDTH = 20;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = 20'd60211;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT
    } t_lir_state;

endpackage

FILE: hw/rtl/lir_in_if.sv
// Input stream interface: one source sample per request.
// Depends on lir_pkg for the default sample width.
interface lir_in_if import lir_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] source_sample;

    modport source (output valid, output source_sample, input ready);
    modport sink   (input valid, input source_sample, output ready);
endinterface

FILE: hw/rtl/lir_out_if.sv
// Output stream interface: one interpolated sample and its last flag per request.
// Depends on lir_pkg for the default sample width.
interface lir_out_if import lir_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           last;

    modport source (output valid, output out_sample, output last, input ready);
    modport sink   (input valid, input out_sample, input last, output ready);
endinterface

FILE: hw/rtl/lir_interp_unit.sv
// Shared interpolation unit: registered (cur - prev) * frac, then truncation
// toward zero and the add of prev. Depends on lir_pkg for parameter defaults.
module lir_interp_unit import lir_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [SAMPLE_WIDTH-1:0] i_prev,
    input  logic [SAMPLE_WIDTH-1:0] i_cur,
    input  logic [FRAC_BITS-1:0]    i_frac,
    output logic [SAMPLE_WIDTH-1:0] o_value
);
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int Q_W    = PROD_W - FRAC_BITS;
    localparam logic [PROD_W-1:0] BIAS = {{(PROD_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    logic signed [DIFF_W-1:0]       diff;
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W-1:0]       r_prod;
    logic        [SAMPLE_WIDTH-1:0] r_base;
    logic        [PROD_W-1:0]       adj;
    logic        [Q_W-1:0]          quot;
    logic        [Q_W-1:0]          sum;

    // Difference of the two samples and its product with the phase fraction.
    assign diff = $signed({i_cur[SAMPLE_WIDTH-1], i_cur}) -
                  $signed({i_prev[SAMPLE_WIDTH-1], i_prev});
    assign prod = diff * $signed({1'b0, i_frac});

    // Product register; the base sample is held alongside it.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= prod;
            r_base <= i_prev;
        end
    end

    // A negative product gets a bias so that the shift truncates toward zero.
    assign adj  = r_prod[PROD_W-1] ? (r_prod + BIAS) : r_prod;
    assign quot = adj[PROD_W-1:FRAC_BITS];
    assign sum  = {{(Q_W - SAMPLE_WIDTH){r_base[SAMPLE_WIDTH-1]}}, r_base} + quot;
    assign o_value = sum[SAMPLE_WIDTH-1:0];

endmodule

FILE: hw/rtl/linear_interp_resampler_top.sv
// Linear-interpolation resampler, top level.
// A priming sample produces no output. Otherwise each output takes two steps of the shared
// multiplier (multiply, then truncate and add), so a request with n outputs holds the input
// until its outputs, MAX at most, are registered; a full output register stalls it.
// A first output passes the product register and then the output register. Input ready is high
// only while the sequencer is idle. Synchronous active-low reset clears state, step to 60211.
module linear_interp_resampler_top import lir_pkg::*; #(
    parameter int SAMPLE_WIDTH          = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS             = FRAC_BITS_DEF,
    parameter int MAX_OUTPUTS_PER_INPUT = MAX_OUT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [STEP_WIDTH-1:0] i_cfg_wr_data,
    lir_in_if.sink                i_in,
    lir_out_if.source             o_out
);
    localparam int PHASE_W = FRAC_BITS + 3;
    localparam int LOOP_W  = ((PHASE_W > STEP_WIDTH) ? PHASE_W : STEP_WIDTH) + 1;
    localparam int CNT_W   = $clog2(MAX_OUTPUTS_PER_INPUT);
    localparam logic [LOOP_W-1:0] ONE    = LOOP_W'(1) << FRAC_BITS;
    localparam logic [LOOP_W-1:0] PH_MAX = LOOP_W'({PHASE_W{1'b1}});
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);

    t_lir_state               r_state, n_state;
    logic [STEP_WIDTH-1:0]    r_step;
    logic [SAMPLE_WIDTH-1:0]  r_prev;
    logic [SAMPLE_WIDTH-1:0]  r_cur;
    logic                     r_primed;
    logic [PHASE_W-1:0]       r_phase;
    logic [LOOP_W-1:0]        r_ph;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_out_sample;
    logic                     r_out_last;

    logic                     in_acc;
    logic                     ph_below;
    logic                     out_free;
    logic [LOOP_W-1:0]        ph_add;
    logic                     emit_last;
    logic                     c_in_ready;
    logic                     c_mul_load;
    logic                     c_emit;
    logic                     c_empty_done;
    logic [SAMPLE_WIDTH-1:0]  interp_value;

    // Phase after one whole source sample is taken off, clamped to the phase range.
    function automatic logic [PHASE_W-1:0] f_settle(input logic [LOOP_W-1:0] ph);
        logic [LOOP_W-1:0] rem;
        begin
            rem = ph - ONE;
            if (ph < ONE) begin
                return '0;
            end else if (rem > PH_MAX) begin
                return '1;
            end else begin
                return rem[PHASE_W-1:0];
            end
        end
    endfunction

    // Handshake and loop conditions.
    assign in_acc    = i_in.valid && c_in_ready;
    assign ph_below  = (r_ph < ONE);
    assign out_free  = !r_out_valid || o_out.ready;
    assign ph_add    = r_ph + LOOP_W'(r_step);
    assign emit_last = (ph_add >= ONE) || (r_cnt == CNT_LAST);

    // Sequencer outputs.
    always_comb begin
        c_in_ready   = 1'b0;
        c_mul_load   = 1'b0;
        c_emit       = 1'b0;
        c_empty_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                c_in_ready = 1'b1;
            end
            S_MUL: begin
                c_mul_load   = ph_below;
                c_empty_done = !ph_below;
            end
            S_EMIT: begin
                c_emit = out_free;
            end
            default: begin
                c_in_ready = 1'b0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_primed) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = ph_below ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = emit_last ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
        end
    end

    // Block state: previous sample, stored phase and primed flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_phase  <= '0;
            r_primed <= 1'b0;
        end else begin
            if (in_acc && !r_primed) begin
                r_prev   <= i_in.source_sample;
                r_primed <= 1'b1;
            end
            if (c_empty_done) begin
                r_phase <= f_settle(r_ph);
                r_prev  <= r_cur;
            end else if (c_emit && emit_last) begin
                r_phase <= f_settle(ph_add);
                r_prev  <= r_cur;
            end
        end
    end

    // Working phase, output count and the current sample for this request.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur <= i_in.source_sample;
            r_ph  <= LOOP_W'(r_phase);
            r_cnt <= '0;
        end else if (c_emit) begin
            r_ph  <= ph_add;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Shared multiply, truncate and add unit.
    lir_interp_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_load  (c_mul_load),
        .i_prev  (r_prev),
        .i_cur   (r_cur),
        .i_frac  (r_ph[FRAC_BITS-1:0]),
        .o_value (interp_value)
    );

    // Output register: loads when empty or when the waiting sample is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_emit) begin
            r_out_sample <= interp_value;
            r_out_last   <= emit_last;
        end
    end

    assign i_in.ready       = c_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;
    assign o_out.last       = r_out_last;

    // An output is only formed while the working phase is below one.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ph < ONE))
        else $error("output stage entered with phase at or above one");

    // The last output of a request returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_emit && emit_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last output");

    // Work on a request only happens once the block is primed.
    a_busy_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_primed)
        else $error("sequencer busy while not primed");

    // A priming sample produces no work.
    a_prime_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_primed) |=> (r_state == S_IDLE) && r_primed)
        else $error("priming sample started a run");

endmodule
